FILE: hw/rtl/rsa_pkg.sv
// ---------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the region statistics accumulator.
// ---------------------------------------------------------------------------
package rsa_pkg;

  localparam int NUM_CLASSES_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X        = 3'd0,
    CFG_CENTER_Y        = 3'd1,
    CFG_DISK_RADIUS     = 3'd2,
    CFG_LIMB_LIMIT      = 3'd3,
    CFG_PHYSICAL_RADIUS = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] CENTER_X_RST        = 16'd32768;
  localparam logic [15:0] CENTER_Y_RST        = 16'd32768;
  localparam logic [15:0] DISK_RADIUS_RST     = 16'd25600;
  localparam logic [15:0] LIMB_LIMIT_RST      = 16'd4096;
  localparam logic [15:0] PHYSICAL_RADIUS_RST = 16'd11128;

  // pi in Q.20
  localparam logic [21:0] PI_Q20  = 22'd3294199;
  localparam logic [24:0] CNT_MAX = 25'd16777216;
  localparam logic [63:0] FILL_NUM = 64'h1000_0000_0000_0000;  // 2^60

  typedef enum logic [1:0] {
    DIV_RAW  = 2'd0,
    DIV_FILL = 2'd1,
    DIV_CTR  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [24:0]        count;
    logic               seen;
    logic signed [31:0] minv;
    logic signed [31:0] maxv;
    logic signed [47:0] sum;
    logic [47:0]        raw;
    logic [47:0]        ctr;
    logic [47:0]        fill;
  } rec_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic geo1;
    logic geo2;
    logic geo3;
    logic raw_go;
    logic fill_go;
    logic sqrt_go;
    logic rs_mul;
    logic ctr_go;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic clr_last;
    logic div_done;
    logic sqrt_done;
    logic sig_pos;
    logic keep;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: hw/rtl/rsa_pixel_if.sv
// ---------------------------------------------------------------------------
// rsa_pixel_if
// Labelled pixel channel, valid/ready.
// ---------------------------------------------------------------------------
interface rsa_pixel_if;
  logic               valid;
  logic               ready;
  logic [7:0]         class_id;
  logic [11:0]        pos_x;
  logic [11:0]        pos_y;
  logic signed [31:0] intensity;
  logic               intensity_valid;

  modport source (output valid, class_id, pos_x, pos_y, intensity, intensity_valid,
                  input ready);
  modport sink   (input valid, class_id, pos_x, pos_y, intensity, intensity_valid,
                  output ready);
endinterface

FILE: hw/rtl/rsa_record_if.sv
// ---------------------------------------------------------------------------
// rsa_record_if
// Per-class record result channel, valid/ready.
// ---------------------------------------------------------------------------
interface rsa_record_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_class;
  logic [24:0]        pixel_count;
  logic               has_intensity;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic signed [47:0] intensity_sum;
  logic [47:0]        plain_area;
  logic [47:0]        center_area;
  logic [47:0]        fill_factor;

  modport source (output valid, out_class, pixel_count, has_intensity, min_value,
                  max_value, intensity_sum, plain_area, center_area, fill_factor,
                  input ready);
  modport sink   (input valid, out_class, pixel_count, has_intensity, min_value,
                  max_value, intensity_sum, plain_area, center_area, fill_factor,
                  output ready);
endinterface

FILE: hw/rtl/rsa_cfg_if.sv
// ---------------------------------------------------------------------------
// rsa_cfg_if
// Configuration register write channel, valid/ready.
// ---------------------------------------------------------------------------
interface rsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rsa_div.sv
// ---------------------------------------------------------------------------
// rsa_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsa_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  qr;
  logic [W-1:0]  den_q;
  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;

  assign sh   = {acc, qr[W-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};
  assign quo  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      qr    <= num;
      den_q <= den;
    end else if (run) begin
      acc <= ge ? diff[W-1:0] : sh[W-1:0];
      qr  <= {qr[W-2:0], ge};
    end
  end
endmodule

FILE: hw/rtl/rsa_sqrt.sv
// ---------------------------------------------------------------------------
// rsa_sqrt
// Integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module rsa_sqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   val,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int RW = W / 2;
  localparam int CW = $clog2(RW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  v;
  logic [RW+1:0] rem;
  logic [RW+3:0] remsh;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  assign remsh = {rem, v[W-1:W-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = remsh >= trial;
  assign diff  = remsh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(RW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      v    <= {v[W-3:0], 2'b00};
      rem  <= ge ? diff[RW+1:0] : remsh[RW+1:0];
      root <= {root[RW-2:0], ge};
    end
  end
endmodule

FILE: hw/rtl/rsa_ctrl.sv
// ---------------------------------------------------------------------------
// rsa_ctrl
// Sequencer: clearing pass, geometry steps, divides, root, record update.
// ---------------------------------------------------------------------------
module rsa_ctrl import rsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pix_valid,
  output logic    pix_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  typedef enum logic [14:0] {
    S_CLEAR     = 15'h0001,
    S_IDLE      = 15'h0002,
    S_GEO1      = 15'h0004,
    S_GEO2      = 15'h0008,
    S_GEO3      = 15'h0010,
    S_RAW_GO    = 15'h0020,
    S_RAW_WAIT  = 15'h0040,
    S_FILL_GO   = 15'h0080,
    S_FILL_WAIT = 15'h0100,
    S_SQRT_GO   = 15'h0200,
    S_SQRT_WAIT = 15'h0400,
    S_RS        = 15'h0800,
    S_CTR_GO    = 15'h1000,
    S_CTR_WAIT  = 15'h2000,
    S_UPDATE    = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    pix_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_range) state_next = S_GEO1;
        end
      end
      S_GEO1: begin
        cmd.geo1   = 1'b1;
        state_next = S_GEO2;
      end
      S_GEO2: begin
        cmd.geo2   = 1'b1;
        state_next = S_GEO3;
      end
      S_GEO3: begin
        cmd.geo3   = 1'b1;
        state_next = S_RAW_GO;
      end
      S_RAW_GO: begin
        cmd.raw_go = 1'b1;
        state_next = S_RAW_WAIT;
      end
      S_RAW_WAIT: begin
        if (sts.div_done) state_next = sts.sig_pos ? S_FILL_GO : S_UPDATE;
      end
      S_FILL_GO: begin
        cmd.fill_go = 1'b1;
        state_next  = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        if (sts.div_done) state_next = sts.keep ? S_SQRT_GO : S_UPDATE;
      end
      S_SQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_next  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) state_next = S_RS;
      end
      S_RS: begin
        cmd.rs_mul = 1'b1;
        state_next = S_CTR_GO;
      end
      S_CTR_GO: begin
        cmd.ctr_go = 1'b1;
        state_next = S_CTR_WAIT;
      end
      S_CTR_WAIT: begin
        if (sts.div_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

FILE: hw/rtl/rsa_dp.sv
// ---------------------------------------------------------------------------
// rsa_dp
// Datapath: config registers, record memory, geometry, divider, root,
// saturating update and output register.
// ---------------------------------------------------------------------------
module rsa_dp import rsa_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [7:0]         class_id,
  input  logic [11:0]        pos_x,
  input  logic [11:0]        pos_y,
  input  logic signed [31:0] intensity,
  input  logic               intensity_valid,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_class,
  output rec_t               res_rec
);
  localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [11:0] POS_MASK = 12'((64'd1 << COORD_BITS) - 64'd1);

  // config
  logic [15:0] cx, cy, dr, ll, pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= CENTER_X_RST;
      cy <= CENTER_Y_RST;
      dr <= DISK_RADIUS_RST;
      ll <= LIMB_LIMIT_RST;
      pr <= PHYSICAL_RADIUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:        cx <= cfg_data;
        CFG_CENTER_Y:        cy <= cfg_data;
        CFG_DISK_RADIUS:     dr <= cfg_data;
        CFG_LIMB_LIMIT:      ll <= cfg_data;
        CFG_PHYSICAL_RADIUS: pr <= cfg_data;
        default: ;
      endcase
    end
  end

  // record memory
  rec_t          mem [NUM_CLASSES];
  rec_t          rd_rec;
  rec_t          new_rec;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  rec_t          wr_data;

  logic [7:0]         cls_q;
  logic [11:0]        px_q, py_q;
  logic signed [31:0] ival_q;
  logic               iv_q;

  assign wr_en   = cmd.clear_wr | cmd.commit;
  assign wr_addr = cmd.clear_wr ? clr_addr : AW'(cls_q);
  assign wr_data = cmd.clear_wr ? '0 : new_rec;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.accept) rd_rec <= mem[AW'(class_id)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cls_q  <= class_id;
      px_q   <= pos_x & POS_MASK;
      py_q   <= pos_y & POS_MASK;
      ival_q <= intensity;
      iv_q   <= intensity_valid;
    end
  end

  // geometry
  logic [15:0]        r_w;
  logic signed [17:0] dx, dy;
  logic signed [35:0] dxp, dyp;
  logic [15:0]        r_q;
  logic [31:0]        r2, p2;
  logic [34:0]        dx2, dy2;
  logic signed [36:0] sigma;
  logic [31:0]        lim2;
  logic [53:0]        pir2;
  logic               sig_pos;
  logic [31:0]        us;
  logic [63:0]        llsig;
  logic [23:0]        s_q;
  logic [39:0]        rs;

  assign r_w = (dr == '0) ? 16'd1 : dr;
  assign dx  = $signed({2'b00, px_q, 4'b0000}) - $signed({2'b00, cx});
  assign dy  = $signed({2'b00, py_q, 4'b0000}) - $signed({2'b00, cy});
  assign dxp = dx * dx;
  assign dyp = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.geo1) begin
      r_q <= r_w;
      r2  <= r_w * r_w;
      p2  <= pr * pr;
      dx2 <= dxp[34:0];
      dy2 <= dyp[34:0];
    end
    if (cmd.geo2) begin
      sigma <= $signed({5'b00000, r2}) - $signed({2'b00, dx2}) - $signed({2'b00, dy2});
      lim2  <= ll * ll;
      pir2  <= 54'(PI_Q20) * 54'(r2);
    end
    if (cmd.geo3) begin
      sig_pos <= !sigma[36] && (sigma != '0);
      us      <= sigma[31:0];
      llsig   <= 64'(lim2) * 64'(sigma[31:0]);
    end
    if (cmd.rs_mul) rs <= r_q * s_q;
  end

  // divider and root
  logic        div_start;
  logic [63:0] div_num, div_den, div_quo;
  logic        div_done;
  div_sel_t    div_sel;
  logic        sqrt_done;
  logic [23:0] sqrt_root;
  logic [47:0] raw_inc, fill_inc, ctr_inc;

  assign div_start = cmd.raw_go | cmd.fill_go | cmd.ctr_go;

  always_comb begin
    div_num = {8'd0, p2, 24'd0};
    div_den = {24'd0, rs};
    if (cmd.raw_go) begin
      div_num = {16'd0, p2, 16'd0};
      div_den = {32'd0, r2};
    end else if (cmd.fill_go) begin
      div_num = FILL_NUM;
      div_den = {10'd0, pir2};
    end
  end

  rsa_div #(.W(64)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rsa_sqrt #(.W(48)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_go),
    .val   ({us, 16'd0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.raw_go)  div_sel <= DIV_RAW;
    if (cmd.fill_go) div_sel <= DIV_FILL;
    if (cmd.ctr_go)  div_sel <= DIV_CTR;
    if (cmd.geo1) begin
      fill_inc <= '0;
      ctr_inc  <= '0;
    end
    if (div_done) begin
      case (div_sel)
        DIV_RAW:  raw_inc  <= div_quo[47:0];
        DIV_FILL: fill_inc <= div_quo[47:0];
        DIV_CTR:  ctr_inc  <= div_quo[47:0];
        default: ;
      endcase
    end
    if (sqrt_done) s_q <= sqrt_root;
  end

  // record update
  logic signed [48:0] sum49;
  logic [48:0]        raw49, ctr49, fill49;

  assign sum49  = $signed({rd_rec.sum[47], rd_rec.sum}) + $signed({{17{ival_q[31]}}, ival_q});
  assign raw49  = {1'b0, rd_rec.raw}  + {1'b0, raw_inc};
  assign ctr49  = {1'b0, rd_rec.ctr}  + {1'b0, ctr_inc};
  assign fill49 = {1'b0, rd_rec.fill} + {1'b0, fill_inc};

  always_comb begin
    new_rec = rd_rec;
    if (iv_q) begin
      if (!rd_rec.seen || (ival_q < rd_rec.minv)) new_rec.minv = ival_q;
      if (!rd_rec.seen || (ival_q > rd_rec.maxv)) new_rec.maxv = ival_q;
      new_rec.seen = 1'b1;
      if (sum49[48] != sum49[47]) begin
        new_rec.sum = sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        new_rec.sum = sum49[47:0];
      end
    end
    if (rd_rec.count < CNT_MAX) new_rec.count = rd_rec.count + 1'b1;
    new_rec.raw  = raw49[48]  ? '1 : raw49[47:0];
    new_rec.ctr  = ctr49[48]  ? '1 : ctr49[47:0];
    new_rec.fill = fill49[48] ? '1 : fill49[47:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_rec   <= new_rec;
      res_class <= cls_q;
    end
  end

  assign sts.in_range  = 32'(class_id) < NUM_CLASSES;
  assign sts.clr_last  = clr_addr == AW'(NUM_CLASSES - 1);
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.sig_pos   = sig_pos;
  assign sts.keep      = sig_pos && ({16'd0, r2, 16'd0} <= llsig);
  assign sts.out_busy  = res_valid && !res_ready;
endmodule

FILE: hw/rtl/region_stats_accumulator.sv
// ---------------------------------------------------------------------------
// region_stats_accumulator
// Per-class region statistics over a stream of labelled pixels.
// ---------------------------------------------------------------------------
// Each accepted pixel updates the record of its class (count, min, max,
// intensity total, raw area, limb-corrected area, filling factor) and one
// transfer on the result channel returns the whole updated record. Pixels
// whose class is at or above NUM_CLASSES are taken and dropped with no
// result. Pixels are handled one at a time, and the shared divider sets
// the cost: the pixel is taken, three geometry steps follow, then the
// raw-area divide (issue, 64 quotient bits, hand-over), and a pixel off the
// disk is then written back. On the disk a second divide for the filling
// factor follows, after which a pixel beyond the limb limit is written
// back. A pixel kept for the limb-corrected area adds a square root (issue,
// then the root bits), one product step and a third divide before its
// write-back. The result sits in an output register, so the next pixel is
// taken while a record still waits to be collected; a write-back waits
// only while an earlier record is still held there. After reset the record
// memory is cleared in a pass over all NUM_CLASSES records during which no
// pixel is taken; configuration writes are always taken (ready is held
// high) and should only be issued while the block is idle.
// ---------------------------------------------------------------------------
module region_stats_accumulator import rsa_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  rsa_cfg_if.sink      cfg,
  rsa_pixel_if.sink    pix,
  rsa_record_if.source res
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  rec_t    res_rec;
  logic    pix_ready;

  assign cfg.ready = 1'b1;
  assign pix.ready = pix_ready;

  // sequencer
  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_ready (pix_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, record memory and output register
  rsa_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .class_id        (pix.class_id),
    .pos_x           (pix.pos_x),
    .pos_y           (pix.pos_y),
    .intensity       (pix.intensity),
    .intensity_valid (pix.intensity_valid),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_class       (res.out_class),
    .res_rec         (res_rec)
  );

  assign res.pixel_count   = res_rec.count;
  assign res.has_intensity = res_rec.seen;
  assign res.min_value     = res_rec.minv;
  assign res.max_value     = res_rec.maxv;
  assign res.intensity_sum = res_rec.sum;
  assign res.plain_area    = res_rec.raw;
  assign res.center_area   = res_rec.ctr;
  assign res.fill_factor   = res_rec.fill;

  // an in-range pixel holds the block until its record is written back
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && sts.in_range) |=> !pix.ready)
    else $error("pixel taken while another is in flight");

  // a result appears only from a record write-back
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(cmd.commit))
    else $error("result raised without a record update");

  // a write-back never overruns a result still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.out_busy)
    else $error("record update while output register is held");
endmodule
